FILE: hdl/n_queens_subproblem_counter_macros.svh
// Assertion macros for the n-queens subproblem counter.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef N_QUEENS_SUBPROBLEM_COUNTER_MACROS_SVH
`define N_QUEENS_SUBPROBLEM_COUNTER_MACROS_SVH

// same-cycle property, held off during reset
`define NQSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent this cycle, consequent next cycle
`define NQSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/nqsc_pkg.sv
// Shared constants and controller/datapath interface types for the
// n-queens subproblem counter. No dependencies.
package nqsc_pkg;

	localparam int BOARD_W     = 5;
	localparam int COL_W       = 4;
	localparam int COUNT_W     = 40;
	localparam int PREFIX_ROWS = 4;
	localparam int BASE_LEVEL  = PREFIX_ROWS + 1;

	localparam logic [BOARD_W-1:0] BOARD_RESET = BOARD_W'(8);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	typedef logic [$clog2(PREFIX_ROWS)-1:0] row_idx_t;

	typedef struct packed {
		logic     init;
		logic     place;
		row_idx_t idx;
		logic     push;
		logic     pop;
		logic     restore;
		logic     scale;
	} dp_cmd_t;

	typedef struct packed {
		logic conflict;
		logic can_push;
		logic at_base;
	} dp_status_t;

endpackage

FILE: hdl/nqsc_datapath.sv
// Datapath: board register, mask registers, level stack memory and count.
// Depends on nqsc_pkg; driven by nqsc_ctrl.
module nqsc_datapath #(
	parameter int MAX_BOARD = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [nqsc_pkg::COL_W-1:0]    first_col,
	input  logic [nqsc_pkg::COL_W-1:0]    second_col,
	input  logic [nqsc_pkg::COL_W-1:0]    third_col,
	input  logic [nqsc_pkg::COL_W-1:0]    fourth_col,
	input  logic                          cfg_wr_en,
	input  logic [nqsc_pkg::BOARD_W-1:0]  cfg_wr_data,
	input  nqsc_pkg::dp_cmd_t             cmd,
	output nqsc_pkg::dp_status_t          status,
	output logic                          prefix_valid,
	output logic [nqsc_pkg::COUNT_W-1:0]  solution_count
);
	import nqsc_pkg::*;

	localparam int W      = MAX_BOARD;
	localparam int LEVELS = MAX_BOARD + 2;
	localparam int LW     = $clog2(LEVELS);
	localparam int CW     = ((LW > BOARD_W) ? LW : BOARD_W) + 1;

	typedef logic [W-1:0] mask_t;
	typedef struct packed {
		mask_t rest;
		mask_t col;
		mask_t pos;
		mask_t neg;
	} frame_t;

	logic [BOARD_W-1:0] board_q;
	logic [COL_W-1:0]   cols_q [PREFIX_ROWS];
	mask_t              col_q, pos_q, neg_q, cand_q;
	logic [LW-1:0]      level_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	frame_t             stack_mem [LEVELS];
	frame_t             rd_q;

	logic [BOARD_W-1:0] n_eff;
	mask_t              full, lsb, sel, next_col, next_pos, next_neg, next_cand;
	logic               hit_leaf, doubled;

	assign n_eff = (board_q > BOARD_W'(MAX_BOARD)) ? BOARD_W'(MAX_BOARD) : board_q;
	assign full  = ~({W{1'b1}} << n_eff);
	assign lsb   = cand_q & (~cand_q + W'(1));
	assign sel   = cmd.push ? lsb : (W'(1) << cols_q[cmd.idx]);

	assign next_col  = col_q & ~sel;
	assign next_pos  = ((pos_q | sel) << 1) & full;
	assign next_neg  = (neg_q | sel) >> 1;
	assign next_cand = next_col & ~(next_pos | next_neg);

	assign hit_leaf = (CW'(level_q) == (CW'(n_eff) + CW'(1)));
	assign doubled  = (CW'(cols_q[0]) < CW'(n_eff >> 1));

	assign status.conflict = ((col_q & sel) == '0) || ((pos_q & sel) != '0) ||
	                         ((neg_q & sel) != '0);
	assign status.can_push = (cand_q != '0) && (level_q < LW'(LEVELS - 1));
	assign status.at_base  = (level_q == LW'(BASE_LEVEL));

	assign prefix_valid   = valid_q;
	assign solution_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q <= BOARD_RESET;
		end else if (cfg_wr_en) begin
			board_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			cols_q[0] <= first_col;
			cols_q[1] <= second_col;
			cols_q[2] <= third_col;
			cols_q[3] <= fourth_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			pos_q   <= '0;
			neg_q   <= '0;
			cand_q  <= '0;
			level_q <= '0;
			count_q <= '0;
			valid_q <= 1'b0;
		end else if (cmd.init) begin
			col_q   <= full;
			pos_q   <= '0;
			neg_q   <= '0;
			cand_q  <= full;
			level_q <= LW'(BASE_LEVEL);
			count_q <= '0;
			valid_q <= 1'b1;
		end else if (cmd.place) begin
			if (status.conflict) begin
				valid_q <= 1'b0;
			end else begin
				col_q  <= next_col;
				pos_q  <= next_pos;
				neg_q  <= next_neg;
				cand_q <= next_cand;
			end
		end else if (cmd.push) begin
			col_q   <= next_col;
			pos_q   <= next_pos;
			neg_q   <= next_neg;
			cand_q  <= next_cand;
			level_q <= level_q + LW'(1);
		end else if (cmd.pop) begin
			level_q <= level_q - LW'(1);
			if (hit_leaf && (count_q != COUNT_MAX)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end else if (cmd.restore) begin
			cand_q <= rd_q.rest;
			col_q  <= rd_q.col;
			pos_q  <= rd_q.pos;
			neg_q  <= rd_q.neg;
		end else if (cmd.scale) begin
			if (doubled) begin
				count_q <= count_q[COUNT_W-1] ? COUNT_MAX : (count_q << 1);
			end
		end
	end

	// level stack: frame of the parent level, with its untried candidates
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stack_mem[level_q] <= '{rest: cand_q & ~lsb, col: col_q, pos: pos_q, neg: neg_q};
		end
		if (cmd.pop) begin
			rd_q <= stack_mem[level_q - LW'(1)];
		end
	end

endmodule

FILE: hdl/nqsc_ctrl.sv
// Controller state machine: prefix check, search sequencing, result strobe.
// Depends on nqsc_pkg and the assertion macro header.
`include "n_queens_subproblem_counter_macros.svh"

module nqsc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  nqsc_pkg::dp_status_t status,
	output nqsc_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);
	import nqsc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREFIX,
		S_SEARCH,
		S_RESTORE,
		S_SCALE
	} state_t;

	state_t   state_q;
	row_idx_t idx_q;
	logic     done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.init = start;
			end
			S_PREFIX: begin
				cmd.place = 1'b1;
				cmd.idx   = idx_q;
			end
			S_SEARCH: begin
				cmd.push = status.can_push;
				cmd.pop  = !status.can_push;
			end
			S_RESTORE: begin
				cmd.restore = 1'b1;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_PREFIX;
						idx_q   <= '0;
					end
				end
				S_PREFIX: begin
					if (status.conflict) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end else if (idx_q == row_idx_t'(PREFIX_ROWS - 1)) begin
						state_q <= S_SEARCH;
					end else begin
						idx_q <= idx_q + row_idx_t'(1);
					end
				end
				S_SEARCH: begin
					if (!status.can_push) begin
						state_q <= status.at_base ? S_SCALE : S_RESTORE;
					end
				end
				S_RESTORE: begin
					state_q <= S_SEARCH;
				end
				S_SCALE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`NQSC_ASSERT(a_done_when_idle, !done_q || (state_q == S_IDLE), "result strobe outside idle")
	`NQSC_ASSERT_NEXT(a_start_enters_prefix, start && (state_q == S_IDLE), (state_q == S_PREFIX) && (idx_q == '0), "accepted item did not enter prefix check")
	`NQSC_ASSERT_NEXT(a_restore_to_search, state_q == S_RESTORE, state_q == S_SEARCH, "restore not followed by search")
	`NQSC_ASSERT_NEXT(a_scale_strobes, state_q == S_SCALE, done_q && (state_q == S_IDLE), "scale did not report")

endmodule

FILE: hdl/n_queens_subproblem_counter.sv
// Channel   | Ports                                              | Handshake
// ----------+----------------------------------------------------+------------------------
// input     | first_col, second_col, third_col, fourth_col       | start & !busy
// result    | prefix_valid, solution_count                       | done, one cycle
// config    | cfg_wr_data (board_size)                           | cfg_wr_en
//
// Prefix check places one row at a time (up to four); an invalid prefix reports
// right away. The search descends by a push and backtracks by a pop and then a
// restore (the level stack memory has a registered read port), and ends with a scale step.
// Results come in the cycle after the last step; the receiver cannot stall.
// Reset clears control, the board register (to 8) and the count; the stack
// memory is not cleared.
// Depends on nqsc_pkg, nqsc_ctrl and nqsc_datapath.
module n_queens_subproblem_counter #(
	parameter int MAX_BOARD = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [nqsc_pkg::COL_W-1:0]    first_col,
	input  logic [nqsc_pkg::COL_W-1:0]    second_col,
	input  logic [nqsc_pkg::COL_W-1:0]    third_col,
	input  logic [nqsc_pkg::COL_W-1:0]    fourth_col,
	input  logic                          cfg_wr_en,
	input  logic [nqsc_pkg::BOARD_W-1:0]  cfg_wr_data,
	output logic                          done,
	output logic                          prefix_valid,
	output logic [nqsc_pkg::COUNT_W-1:0]  solution_count
);
	import nqsc_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	nqsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	nqsc_datapath #(
		.MAX_BOARD (MAX_BOARD)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.first_col      (first_col),
		.second_col     (second_col),
		.third_col      (third_col),
		.fourth_col     (fourth_col),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.cmd            (cmd),
		.status         (status),
		.prefix_valid   (prefix_valid),
		.solution_count (solution_count)
	);

endmodule

FILE: dv/tb_n_queens_subproblem_counter.sv
// Self-checking testbench for n_queens_subproblem_counter: board sizes from 0 to 31,
// directed and random four-row prefixes, each count checked against a bitmask search.
// Depends on nqsc_pkg and the n_queens_subproblem_counter RTL.
module tb_n_queens_subproblem_counter;
	import nqsc_pkg::*;

	localparam int MAX_BOARD   = 16;
	localparam int LEVELS      = MAX_BOARD + 2;
	localparam int WATCHDOG    = 4000000;
	localparam int TAIL_CYCLES = 50;

	typedef struct packed {
		bit [COL_W-1:0] first_col;
		bit [COL_W-1:0] second_col;
		bit [COL_W-1:0] third_col;
		bit [COL_W-1:0] fourth_col;
	} placement_t;

	typedef struct packed {
		bit               prefix_valid;
		bit [COUNT_W-1:0] solution_count;
	} tally_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [COL_W-1:0]   first_col = '0;
	logic [COL_W-1:0]   second_col = '0;
	logic [COL_W-1:0]   third_col = '0;
	logic [COL_W-1:0]   fourth_col = '0;
	logic               cfg_wr_en = 1'b0;
	logic [BOARD_W-1:0] cfg_wr_data = '0;
	logic               done;
	logic               prefix_valid;
	logic [COUNT_W-1:0] solution_count;

	placement_t         prefix_q[$];
	tally_t             tally_q[$];
	bit [BOARD_W-1:0]   board_reg = BOARD_RESET;
	int                 mismatches = 0;
	int                 idle_cycles = 0;
	int                 gap_left = 0;
	int                 burst_left = 1;
	tally_t             want;

	n_queens_subproblem_counter #(
		.MAX_BOARD(MAX_BOARD)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.first_col      (first_col),
		.second_col     (second_col),
		.third_col      (third_col),
		.fourth_col     (fourth_col),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.done           (done),
		.prefix_valid   (prefix_valid),
		.solution_count (solution_count)
	);

	initial forever #5 clk = ~clk;

	function automatic tally_t count_completions(input bit [BOARD_W-1:0] board,
			input placement_t p);
		int         n;
		int         h;
		bit [31:0]  full;
		bit [31:0]  r;
		bit [31:0]  b;
		bit [31:0]  lsb;
		bit [31:0]  cdt [LEVELS];
		bit [31:0]  colm [LEVELS];
		bit [31:0]  pos [LEVELS];
		bit [31:0]  neg [LEVELS];
		bit [COL_W-1:0] cols [4];
		bit [COUNT_W-1:0] total;
		n = (board > MAX_BOARD) ? MAX_BOARD : int'(board);
		full = (32'd1 << n) - 32'd1;
		for (int i = 0; i < LEVELS; i++) begin
			cdt[i] = '0;
			colm[i] = '0;
			pos[i] = '0;
			neg[i] = '0;
		end
		cols = '{p.first_col, p.second_col, p.third_col, p.fourth_col};
		colm[1] = full;
		r = full;
		total = '0;
		for (h = 1; h <= PREFIX_ROWS; h++) begin
			b = 32'd1 << cols[h-1];
			if ((colm[h] & b) == 0 || (pos[h] & b) != 0 || (neg[h] & b) != 0)
				return '{1'b0, '0};
			colm[h+1] = colm[h] & ~b;
			pos[h+1] = ((pos[h] | b) << 1) & full;
			neg[h+1] = (neg[h] | b) >> 1;
			r = colm[h+1] & ~(pos[h+1] | neg[h+1]);
		end
		h = BASE_LEVEL;
		while (1) begin
			if (r != 0 && h + 1 < LEVELS) begin
				lsb = r & (~r + 32'd1);
				cdt[h+1] = r & ~lsb;
				colm[h+1] = colm[h] & ~lsb;
				pos[h+1] = ((pos[h] | lsb) << 1) & full;
				neg[h+1] = (neg[h] | lsb) >> 1;
				r = colm[h+1] & ~(pos[h+1] | neg[h+1]);
				h++;
			end else begin
				r = cdt[h];
				h--;
				if (h == n && total < COUNT_MAX)
					total++;
				if (h < BASE_LEVEL)
					break;
			end
		end
		// mirror symmetry
		if (p.first_col < (n >> 1))
			total = (total > (COUNT_MAX >> 1)) ? COUNT_MAX : total << 1;
		return '{1'b1, total};
	endfunction

	function automatic placement_t random_prefix(input bit [BOARD_W-1:0] board);
		int         n;
		placement_t p;
		tally_t     t;
		n = (board > MAX_BOARD) ? MAX_BOARD : int'(board);
		p = placement_t'($urandom_range(0, 65535));
		// big boards: force a clash so the search stays short
		if (n >= 15) begin
			case ($urandom_range(0, 2))
				0: p.second_col = p.first_col;
				1: p.third_col = p.second_col;
				default: p.fourth_col = p.third_col;
			endcase
			return p;
		end
		if (n >= PREFIX_ROWS && $urandom_range(0, 3) != 0) begin
			repeat (40) begin
				p.first_col = COL_W'($urandom_range(0, n - 1));
				p.second_col = COL_W'($urandom_range(0, n - 1));
				p.third_col = COL_W'($urandom_range(0, n - 1));
				p.fourth_col = COL_W'($urandom_range(0, n - 1));
				t = count_completions(board, p);
				if (t.prefix_valid)
					return p;
			end
		end
		return p;
	endfunction

	task automatic push_random(input int num);
		repeat (num) prefix_q.push_back(random_prefix(board_reg));
	endtask

	task automatic drain();
		do @(posedge clk);
		while (prefix_q.size() != 0 || tally_q.size() != 0 || start || busy);
	endtask

	task automatic write_board(input bit [BOARD_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		board_reg = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// driver: bursts of items with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (start && !busy) begin
				tally_q.push_back(count_completions(board_reg, prefix_q[0]));
				void'(prefix_q.pop_front());
				burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end
			if (start && busy) begin
				// hold the item
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (prefix_q.size() != 0) begin
				start <= 1'b1;
				first_col <= prefix_q[0].first_col;
				second_col <= prefix_q[0].second_col;
				third_col <= prefix_q[0].third_col;
				fourth_col <= prefix_q[0].fourth_col;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: watchdog expired", $time);
				$display("n_queens_subproblem_counter test failed");
				$finish;
			end
			if (done) begin
				if (tally_q.size() == 0) begin
					$display("%0t: unexpected result, expected none got valid=%0b count=%0d",
						$time, prefix_valid, solution_count);
					mismatches++;
				end else begin
					want = tally_q.pop_front();
					if (prefix_valid !== want.prefix_valid) begin
						$display("%0t: prefix_valid expected %0b got %0b",
							$time, want.prefix_valid, prefix_valid);
						mismatches++;
					end
					if (solution_count !== want.solution_count) begin
						$display("%0t: solution_count expected %0d got %0d",
							$time, want.solution_count, solution_count);
						mismatches++;
					end
				end
			end
		end
	end

	initial begin
		int sizes [7] = '{5, 6, 7, 9, 10, 12, 13};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset board size
		prefix_q.push_back('{4'd0, 4'd0, 4'd0, 4'd0});
		prefix_q.push_back('{4'd0, 4'd2, 4'd4, 4'd1});
		prefix_q.push_back('{4'd7, 4'd5, 4'd3, 4'd1});
		prefix_q.push_back('{4'd3, 4'd0, 4'd4, 4'd7});
		prefix_q.push_back('{4'd4, 4'd0, 4'd3, 4'd5});
		prefix_q.push_back('{4'd15, 4'd0, 4'd2, 4'd4});
		prefix_q.push_back('{4'd0, 4'd2, 4'd4, 4'd9});
		prefix_q.push_back('{4'd0, 4'd1, 4'd3, 4'd5});
		prefix_q.push_back('{4'd1, 4'd0, 4'd2, 4'd4});
		prefix_q.push_back('{4'd0, 4'd2, 4'd4, 4'd4});
		prefix_q.push_back('{4'd15, 4'd15, 4'd15, 4'd15});
		prefix_q.push_back('{4'd5, 4'd7, 4'd1, 4'd3});
		prefix_q.push_back('{4'd2, 4'd5, 4'd7, 4'd0});
		push_random(15);
		drain();

		// smallest board with a fit: whole board placed by the prefix
		write_board(5'd4);
		prefix_q.push_back('{4'd1, 4'd3, 4'd0, 4'd2});
		prefix_q.push_back('{4'd2, 4'd0, 4'd3, 4'd1});
		push_random(10);
		drain();

		// boards too small for any prefix
		write_board(5'd0);
		push_random(4);
		drain();
		write_board(5'd3);
		push_random(4);
		drain();

		foreach (sizes[i]) begin
			write_board(sizes[i][BOARD_W-1:0]);
			push_random(8);
			drain();
		end

		// oversize setting clamps to the largest board
		write_board(5'd31);
		prefix_q.push_back('{4'd8, 4'd0, 4'd2, 4'd3});
		push_random(5);
		drain();

		write_board(5'd16);
		prefix_q.push_back('{4'd7, 4'd9, 4'd11, 4'd12});
		push_random(4);
		drain();

		write_board(5'd20);
		push_random(3);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tally_q.size() == 0)
			$display("n_queens_subproblem_counter test passed");
		else
			$display("n_queens_subproblem_counter test failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/nqsc_pkg.sv
hdl/nqsc_datapath.sv
hdl/nqsc_ctrl.sv
hdl/n_queens_subproblem_counter.sv
dv/tb_n_queens_subproblem_counter.sv
